// ----- design/p2c_pkg.sv -----
// Shared types, constants and the CORDIC tables of the scan polar-to-cartesian core.
// Used by every module under design/; depends on nothing.
`default_nettype none

package p2c_pkg;

  localparam int unsigned MAX_RAYS      = 4096;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_ENTRIES  = 24;
  localparam int unsigned STAGES =
    (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  localparam int unsigned RANGE_W  = 24;
  localparam int unsigned RAY_W    = 12;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned POINT_W  = 26;
  localparam int unsigned GUARD    = 8;
  localparam int unsigned KINV_W   = 30;
  localparam int unsigned PROD_W   = RANGE_W + KINV_W;
  // Working widths of the rotation: x and y reach about range * 2^GUARD, z a quarter turn.
  localparam int unsigned XW       = 35;
  localparam int unsigned ZW       = 34;
  localparam int unsigned SUM_W    = 36;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_RANGE_LO    = 3'd2,
    CFG_RANGE_HI    = 3'd3,
    CFG_OFFSET_X    = 3'd4,
    CFG_OFFSET_Y    = 3'd5
  } cfg_reg_e;

  // One item on its way through the rotation.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RAY_W-1:0]     ray;
  } p2c_vec_t;

  typedef logic [KINV_W-1:0] atan_t;

  // atan(2^-i) with a full turn of 2^32.
  localparam atan_t ATAN_TURN32 [ATAN_ENTRIES] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // Inverse CORDIC gain in Q30, evaluated at elaboration only: the product of
  // (1 + 2^-2i) in Q60, an integer square root, then a shift-subtract division.
  function automatic logic [KINV_W-1:0] gain_inv_f();
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    logic [63:0] quo;
    p = 64'd1 << 60;
    for (int i = 0; i < int'(STAGES); i++) begin
      p = p + (p >> (2 * i));
    end
    v   = p;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt != 64'd0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    if (res == 64'd0) begin
      res = 64'd1;
    end
    rem = 64'd0;
    quo = 64'd0;
    for (int k = 60; k >= 0; k--) begin
      rem = {rem[62:0], (k == 60)};
      if (rem >= res) begin
        rem    = rem - res;
        quo[k] = 1'b1;
      end
    end
    return quo[KINV_W-1:0];
  endfunction

  localparam logic [KINV_W-1:0] KINV = gain_inv_f();

endpackage

`default_nettype wire

// ----- design/p2c_front.sv -----
// Front end: sample filter, angle and gain multiplies, half-turn fold.
// Two register stages; depends on p2c_pkg.
`default_nettype none

module p2c_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          in_valid_i,
  input  wire logic [p2c_pkg::RANGE_W-1:0]   range_value_i,
  input  wire logic [p2c_pkg::RAY_W-1:0]     ray_index_i,
  input  wire logic                          sample_invalid_i,
  input  wire logic [p2c_pkg::ANGLE_W-1:0]   start_angle_i,
  input  wire logic [p2c_pkg::ANGLE_W-1:0]   angle_step_i,
  input  wire logic [p2c_pkg::RANGE_W-1:0]   range_lo_i,
  input  wire logic [p2c_pkg::RANGE_W-1:0]   range_hi_i,
  output logic                               vld_o,
  output p2c_pkg::p2c_vec_t                  vec_o
);
  import p2c_pkg::*;

  logic                   keep;
  logic                   vld_a_q;
  logic [PROD_W-1:0]      prod_a_q;
  logic [ANGLE_W-1:0]     ang_a_q;
  logic [RAY_W-1:0]       ray_a_q;
  logic [RAY_W+ANGLE_W-1:0] ang_full;
  logic [PROD_W:0]        prod_rnd;
  logic [XW-1:0]          x0;
  logic [ANGLE_W-1:0]     ang_sum;
  logic [ANGLE_W-1:0]     ang_chk;
  logic                   fold;
  logic [ANGLE_W-1:0]     ang_fold;
  p2c_vec_t               vec_d;
  logic                   vld_b_q;
  p2c_vec_t               vec_b_q;

  // At the present index width the ray compare always passes; it matters for a smaller MAX_RAYS.
  assign keep = !sample_invalid_i && (range_value_i >= range_lo_i) &&
                (range_value_i <= range_hi_i) &&
                ({1'b0, ray_index_i} < (RAY_W+1)'(MAX_RAYS));

  // Only the low bits of index times step matter: the angle wraps at a full turn.
  assign ang_full = ray_index_i * angle_step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (adv_i) begin
      vld_a_q <= in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_a_q <= range_value_i * KINV;
      ang_a_q  <= ang_full[ANGLE_W-1:0];
      ray_a_q  <= ray_index_i;
    end
  end

  always_comb begin
    prod_rnd = {1'b0, prod_a_q} + ((PROD_W+1)'(1) << (30 - GUARD - 1));
    x0       = XW'(prod_rnd[PROD_W:30-GUARD]);
    ang_sum  = start_angle_i + ang_a_q;
    ang_chk  = ang_sum + ANGLE_W'(16384);
    fold     = ang_chk[ANGLE_W-1];
    ang_fold = fold ? (ang_sum ^ ANGLE_W'(32768)) : ang_sum;
    vec_d.x   = fold ? -$signed(x0) : $signed(x0);
    vec_d.y   = '0;
    vec_d.z   = {{(ZW-ANGLE_W-16){ang_fold[ANGLE_W-1]}}, ang_fold, 16'd0};
    vec_d.ray = ray_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (adv_i) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec_b_q <= vec_d;
    end
  end

  assign vld_o = vld_b_q;
  assign vec_o = vec_b_q;

  a_invalid_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && in_valid_i && sample_invalid_i) |=> !vld_a_q)
    else $error("flagged sample entered the pipeline");

  a_window_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && in_valid_i && (range_lo_i > range_hi_i)) |=> !vld_a_q)
    else $error("sample passed an empty range window");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(vld_a_q) && $stable(vld_b_q)))
    else $error("front stage valid bits moved during a stall");

endmodule

`default_nettype wire

// ----- design/p2c_cordic.sv -----
// Rotation-mode CORDIC, one register stage per micro-rotation.
// Depends on p2c_pkg for the stage count, widths and the arctangent table.
`default_nettype none

module p2c_cordic (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              vld_i,
  input  wire p2c_pkg::p2c_vec_t vec_i,
  output logic                   vld_o,
  output p2c_pkg::p2c_vec_t      vec_o
);
  import p2c_pkg::*;

  logic     vld_q [STAGES];
  p2c_vec_t vec_q [STAGES];

  for (genvar i = 0; i < int'(STAGES); i++) begin : g_stage
    logic                 src_vld;
    p2c_vec_t             src;
    p2c_vec_t             nxt;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;

    if (i == 0) begin : g_first
      assign src_vld = vld_i;
      assign src     = vec_i;
    end else begin : g_next
      assign src_vld = vld_q[i-1];
      assign src     = vec_q[i-1];
    end

    always_comb begin
      dx = src.y >>> i;
      dy = src.x >>> i;
      da = $signed(ZW'(ATAN_TURN32[i]));
      nxt.ray = src.ray;
      // Rotate towards zero residual angle; z >= 0 turns counter-clockwise.
      if (!src.z[ZW-1]) begin
        nxt.x = src.x - dx;
        nxt.y = src.y + dy;
        nxt.z = src.z - da;
      end else begin
        nxt.x = src.x + dx;
        nxt.y = src.y - dy;
        nxt.z = src.z + da;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        vec_q[i] <= nxt;
      end
    end
  end

  assign vld_o = vld_q[STAGES-1];
  assign vec_o = vec_q[STAGES-1];

  a_first_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (vld_q[0] == $past(vld_i)))
    else $error("first rotation stage lost or invented an item");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(vld_o))
    else $error("last rotation stage moved during a stall");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (vld_o == $past(vld_q[STAGES-2])))
    else $error("last rotation stage lost or invented an item");

endmodule

`default_nettype wire

// ----- design/p2c_back.sv -----
// Back end: rounding off the guard bits, sensor offset and saturation into the output register.
// Depends on p2c_pkg.
`default_nettype none

module p2c_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              adv_i,
  input  wire logic                              vld_i,
  input  wire p2c_pkg::p2c_vec_t                 vec_i,
  input  wire logic signed [p2c_pkg::POINT_W-1:0] offset_x_i,
  input  wire logic signed [p2c_pkg::POINT_W-1:0] offset_y_i,
  output logic                                   out_valid_o,
  output logic signed [p2c_pkg::POINT_W-1:0]     point_x_o,
  output logic signed [p2c_pkg::POINT_W-1:0]     point_y_o,
  output logic [p2c_pkg::RAY_W-1:0]              point_ray_o
);
  import p2c_pkg::*;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (POINT_W-1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(64'sd1 <<< (POINT_W-1)));

  logic signed [SUM_W-1:0]   x_rnd;
  logic signed [SUM_W-1:0]   y_rnd;
  logic signed [SUM_W-1:0]   x_sum;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [POINT_W-1:0] x_sat;
  logic signed [POINT_W-1:0] y_sat;
  logic                      out_valid_q;
  logic signed [POINT_W-1:0] point_x_q;
  logic signed [POINT_W-1:0] point_y_q;
  logic [RAY_W-1:0]          point_ray_q;

  always_comb begin
    x_rnd = (SUM_W'(vec_i.x) + SUM_W'(128)) >>> GUARD;
    y_rnd = (SUM_W'(vec_i.y) + SUM_W'(128)) >>> GUARD;
    x_sum = x_rnd + SUM_W'(offset_x_i);
    y_sum = y_rnd + SUM_W'(offset_y_i);
    priority if (x_sum > OUT_MAX) begin
      x_sat = POINT_W'(OUT_MAX);
    end else if (x_sum < OUT_MIN) begin
      x_sat = POINT_W'(OUT_MIN);
    end else begin
      x_sat = x_sum[POINT_W-1:0];
    end
    priority if (y_sum > OUT_MAX) begin
      y_sat = POINT_W'(OUT_MAX);
    end else if (y_sum < OUT_MIN) begin
      y_sat = POINT_W'(OUT_MIN);
    end else begin
      y_sat = y_sum[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      point_x_q   <= x_sat;
      point_y_q   <= y_sat;
      point_ray_q <= vec_i.ray;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = point_x_q;
  assign point_y_o   = point_y_q;
  assign point_ray_o = point_ray_q;

endmodule

`default_nettype wire

// ----- design/scan_polar_to_cartesian_core.sv -----
// Scan polar-to-cartesian core: one laser range item in, at most one planar point out.
// Stages: from input to output a point passes 19 register stages (two front stages,
// one per CORDIC micro-rotation, one output stage).
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a point waits on a stalled output. Reset clears the valid bits and sets the
// configuration registers to their defaults (the range maximum all ones, the rest zero).
`default_nettype none

module scan_polar_to_cartesian_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [p2c_pkg::RANGE_W-1:0]         range_value_i,
  input  wire logic [p2c_pkg::RAY_W-1:0]           ray_index_i,
  input  wire logic                                sample_invalid_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [p2c_pkg::POINT_W-1:0]       point_x_o,
  output logic signed [p2c_pkg::POINT_W-1:0]       point_y_o,
  output logic [p2c_pkg::RAY_W-1:0]                point_ray_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [p2c_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [p2c_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import p2c_pkg::*;

  logic [ANGLE_W-1:0]        start_angle_q;
  logic [ANGLE_W-1:0]        angle_step_q;
  logic [RANGE_W-1:0]        range_lo_q;
  logic [RANGE_W-1:0]        range_hi_q;
  logic signed [POINT_W-1:0] offset_x_q;
  logic signed [POINT_W-1:0] offset_y_q;
  logic                      adv;
  logic                      front_vld;
  p2c_vec_t                  front_vec;
  logic                      rot_vld;
  p2c_vec_t                  rot_vec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
      range_lo_q    <= '0;
      range_hi_q    <= '1;
      offset_x_q    <= '0;
      offset_y_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_START_ANGLE: start_angle_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i[ANGLE_W-1:0];
        CFG_RANGE_LO:    range_lo_q    <= cfg_data_i[RANGE_W-1:0];
        CFG_RANGE_HI:    range_hi_q    <= cfg_data_i[RANGE_W-1:0];
        CFG_OFFSET_X:    offset_x_q    <= $signed(cfg_data_i[POINT_W-1:0]);
        CFG_OFFSET_Y:    offset_y_q    <= $signed(cfg_data_i[POINT_W-1:0]);
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished point is held by the receiver.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  p2c_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .in_valid_i       (in_valid_i),
    .range_value_i    (range_value_i),
    .ray_index_i      (ray_index_i),
    .sample_invalid_i (sample_invalid_i),
    .start_angle_i    (start_angle_q),
    .angle_step_i     (angle_step_q),
    .range_lo_i       (range_lo_q),
    .range_hi_i       (range_hi_q),
    .vld_o            (front_vld),
    .vec_o            (front_vec)
  );

  p2c_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (front_vld),
    .vec_i  (front_vec),
    .vld_o  (rot_vld),
    .vec_o  (rot_vec)
  );

  p2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .vld_i       (rot_vld),
    .vec_i       (rot_vec),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .out_valid_o (out_valid_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_ray_o (point_ray_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held point");

  a_point_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (out_valid_o == $past(rot_vld)))
    else $error("output register did not take the next rotation result");

  a_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(point_x_o) && $stable(point_ray_o)))
    else $error("held point changed");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the scan polar-to-cartesian core: range items in, planar points out.
// Depends on p2c_pkg for the port widths and the register codes, and on the core itself.
`timescale 1ns / 1ps

module testbench;
  import p2c_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic [RAY_W-1:0]          ray;
  } point_t;

  localparam int ATAN_ROWS     = 24;
  localparam int STAGE_COUNT   =
    (p2c_pkg::CORDIC_STAGES > ATAN_ROWS) ? ATAN_ROWS : p2c_pkg::CORDIC_STAGES;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int PHASES        = 8;
  localparam int CALM_PHASE    = 3;
  localparam int HOLD_CYCLES   = 150;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam logic [RANGE_W-1:0]        RANGE_TOP = 24'hFFFFFF;
  localparam logic signed [POINT_W-1:0] POINT_MAX = 26'sh1FFFFFF;
  localparam logic signed [POINT_W-1:0] POINT_MIN = -26'sh2000000;

  // Arctangent of 2^-i, full turn 2^32.
  localparam logic [31:0] ATAN_Q32 [ATAN_ROWS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [RANGE_W-1:0]        range_value_i;
  logic [RAY_W-1:0]          ray_index_i;
  logic                      sample_invalid_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [POINT_W-1:0] point_x_o;
  logic signed [POINT_W-1:0] point_y_o;
  logic [RAY_W-1:0]          point_ray_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  // Local copy of the configuration registers.
  logic [ANGLE_W-1:0]        m_start;
  logic [ANGLE_W-1:0]        m_step;
  logic [RANGE_W-1:0]        m_min;
  logic [RANGE_W-1:0]        m_max;
  logic signed [POINT_W-1:0] m_offx;
  logic signed [POINT_W-1:0] m_offy;
  u64_t                      gain_q30;

  point_t expected_points [$];
  point_t oldest_point;
  int     errors         = 0;
  int     samples_sent   = 0;
  int     points_checked = 0;
  int     writes_done    = 0;
  int     input_stalls   = 0;
  int     cycle_count    = 0;
  int     hold_left      = 0;
  bit     calm           = 1'b0;

  scan_polar_to_cartesian_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .range_value_i    (range_value_i),
    .ray_index_i      (ray_index_i),
    .sample_invalid_i (sample_invalid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .point_ray_o      (point_ray_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic u64_t int_sqrt(input u64_t v);
    u64_t res;
    u64_t bitv;
    res  = 0;
    bitv = u64_t'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic u64_t cordic_gain_inverse();
    u64_t p;
    u64_t s;
    p = u64_t'(1) << 60;
    for (int i = 0; i < STAGE_COUNT; i++) p = p + (p >> (2 * i));
    s = int_sqrt(p);
    if (s == 0) s = 1;
    return (u64_t'(1) << 60) / s;
  endfunction

  function automatic longint clamp_point(input longint v);
    if (v > longint'(POINT_MAX)) return longint'(POINT_MAX);
    if (v < longint'(POINT_MIN)) return longint'(POINT_MIN);
    return v;
  endfunction

  // Works out the point of one range item; returns 0 when the item is rejected.
  function automatic bit predict_point(input logic [RANGE_W-1:0] r, input logic [RAY_W-1:0] ray,
                                       input logic bad, output point_t pt);
    logic [ANGLE_W-1:0]        ang;
    logic [ANGLE_W-1:0]        folded;
    logic signed [ANGLE_W-1:0] ang_s;
    longint                    x;
    longint                    y;
    longint                    z;
    longint                    dx;
    longint                    dy;
    longint                    offs;
    longint                    px;
    longint                    py;
    pt = '0;
    if (bad || r < m_min || r > m_max || ray >= p2c_pkg::MAX_RAYS) return 1'b0;
    ang = m_start + ray * m_step;
    x   = longint'((u64_t'(r) * gain_q30 + (u64_t'(1) << 21)) >> 22);
    y   = 0;
    // Angles in the left half-plane are turned by half a turn first.
    folded = ang + 16'd16384;
    if (folded[15]) begin
      x       = -x;
      ang[15] = ~ang[15];
    end
    ang_s = ang;
    z     = ang_s;
    z     = z * 65536;
    for (int i = 0; i < STAGE_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_Q32[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_Q32[i]);
      end
    end
    offs = m_offx;
    px   = clamp_point(((x + 128) >>> 8) + offs);
    offs = m_offy;
    py   = clamp_point(((y + 128) >>> 8) + offs);
    pt.x   = px[POINT_W-1:0];
    pt.y   = py[POINT_W-1:0];
    pt.ray = ray;
    return 1'b1;
  endfunction

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_START_ANGLE: m_start = data[ANGLE_W-1:0];
      CFG_ANGLE_STEP:  m_step  = data[ANGLE_W-1:0];
      CFG_RANGE_LO:    m_min   = data[RANGE_W-1:0];
      CFG_RANGE_HI:    m_max   = data[RANGE_W-1:0];
      CFG_OFFSET_X:    m_offx  = data;
      CFG_OFFSET_Y:    m_offy  = data;
      default: ;
    endcase
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, data);
    writes_done++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one item and waits until the core takes it.
  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic [RAY_W-1:0] ray,
                             input logic bad);
    point_t pt;
    while (!calm && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    range_value_i    = r;
    ray_index_i      = ray;
    sample_invalid_i = bad;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    if (predict_point(r, ray, bad, pt)) expected_points = {expected_points, pt};
    samples_sent++;
  endtask

  // Rejected items leave nothing to wait for, so the pipeline is given time to empty.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x %0d y %0d ray %0d",
                 $time, point_x_o, point_y_o, point_ray_o);
        errors++;
      end else begin
        oldest_point = expected_points.pop_front();
        check_field("point_x", oldest_point.x, point_x_o);
        check_field("point_y", oldest_point.y, point_y_o);
        check_field("point_ray", oldest_point.ray, point_ray_o);
        points_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and a long hold-off when asked.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = !calm && ($urandom_range(99) < 33);
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(24'd0, 12'd0, 1'b0);
    send_sample(RANGE_TOP, 12'd4095, 1'b0);
    send_sample(24'd12345, 12'd7, 1'b1);
    send_sample(RANGE_W'($urandom), RAY_W'($urandom), 1'b0);
    wait_idle();
  endtask

  task automatic test_quadrant_folding();
    write_register(CFG_ANGLE_STEP, 26'h0008000);
    write_register(CFG_START_ANGLE, 26'd16383);
    send_sample(24'h0A0000, 12'd0, 1'b0);
    send_sample(24'h0A0000, 12'd1, 1'b0);
    wait_idle();
    write_register(CFG_START_ANGLE, 26'd16384);
    send_sample(24'h0A0000, 12'd0, 1'b0);
    send_sample(24'h0A0000, 12'd1, 1'b0);
    wait_idle();
    write_register(CFG_START_ANGLE, 26'd65535);
    write_register(CFG_ANGLE_STEP, 26'h0007FFF);
    send_sample(24'h123456, 12'd4095, 1'b0);
    wait_idle();
    write_register(CFG_START_ANGLE, 26'd32768);
    write_register(CFG_ANGLE_STEP, 26'd0);
    send_sample(24'h054321, 12'd5, 1'b0);
    wait_idle();
  endtask

  task automatic test_range_window();
    write_register(CFG_RANGE_LO, 26'd1000);
    write_register(CFG_RANGE_HI, 26'd2000);
    send_sample(24'd999, 12'd1, 1'b0);
    send_sample(24'd1000, 12'd2, 1'b0);
    send_sample(24'd2000, 12'd3, 1'b0);
    send_sample(24'd2001, 12'd4, 1'b0);
    wait_idle();
    // An empty window, with the minimum above the maximum, rejects everything.
    write_register(CFG_RANGE_LO, 26'd5);
    write_register(CFG_RANGE_HI, 26'd4);
    send_sample(24'd4, 12'd5, 1'b0);
    send_sample(24'd5, 12'd6, 1'b0);
    wait_idle();
    write_register(CFG_RANGE_LO, 26'd0);
    write_register(CFG_RANGE_HI, 26'(RANGE_TOP));
  endtask

  task automatic test_saturation();
    write_register(CFG_START_ANGLE, 26'd0);
    write_register(CFG_OFFSET_X, 26'(POINT_MAX));
    write_register(CFG_OFFSET_Y, 26'(POINT_MIN));
    send_sample(RANGE_TOP, 12'd1, 1'b0);
    wait_idle();
    write_register(CFG_START_ANGLE, 26'd32768);
    write_register(CFG_OFFSET_X, 26'(POINT_MIN));
    send_sample(RANGE_TOP, 12'd2, 1'b0);
    wait_idle();
    write_register(CFG_START_ANGLE, 26'd16384);
    write_register(CFG_OFFSET_Y, 26'(POINT_MAX));
    send_sample(RANGE_TOP, 12'd3, 1'b0);
    wait_idle();
    write_register(CFG_OFFSET_X, 26'd0);
    write_register(CFG_OFFSET_Y, 26'd0);
    write_register(CFG_START_ANGLE, 26'd0);
  endtask

  task automatic test_unused_registers();
    write_register(CFG_UNUSED_LO, '1);
    write_register(CFG_UNUSED_HI, '1);
    send_sample(24'h00F000, 12'd9, 1'b0);
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering, so the pipeline fills.
  task automatic test_backpressure();
    write_register(CFG_ANGLE_STEP, 26'd37);
    hold_left = HOLD_CYCLES;
    calm      = 1'b1;
    for (int k = 0; k < 80; k++) send_sample(RANGE_W'($urandom), RAY_W'(k), 1'b0);
    calm = 1'b0;
    wait_idle();
  endtask

  task automatic randomise_settings();
    logic [31:0]        junk;
    logic [ANGLE_W-1:0] ang;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    logic [RANGE_W-1:0] tmp;
    logic [POINT_W-1:0] off;
    junk = $urandom;
    case ($urandom_range(3))
      0: ang = 16'h0000;
      1: ang = 16'hFFFF;
      default: ang = ANGLE_W'($urandom);
    endcase
    write_register(CFG_START_ANGLE, {junk[9:0], ang});
    case ($urandom_range(4))
      0: ang = 16'h8000;
      1: ang = 16'h7FFF;
      2: ang = ANGLE_W'($urandom);
      default: ang = ANGLE_W'($signed($urandom_range(128)) - 64);
    endcase
    write_register(CFG_ANGLE_STEP, {junk[19:10], ang});
    case ($urandom_range(4))
      0, 1: begin
        lo = 24'd0;
        hi = RANGE_TOP;
      end
      2: begin
        lo = 24'd0;
        hi = RANGE_W'($urandom);
      end
      3: begin
        lo = RANGE_W'($urandom);
        hi = RANGE_TOP;
      end
      default: begin
        lo = RANGE_W'($urandom);
        hi = RANGE_W'($urandom);
      end
    endcase
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    write_register(CFG_RANGE_LO, {junk[21:20], lo});
    write_register(CFG_RANGE_HI, {junk[23:22], hi});
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(4))
        0: off = 26'(POINT_MAX);
        1: off = 26'(POINT_MIN);
        2: off = '0;
        3: off = POINT_W'($signed($urandom_range(65536)) - 32768);
        default: off = POINT_W'($urandom);
      endcase
      write_register(k == 0 ? CFG_OFFSET_X : CFG_OFFSET_Y, off);
    end
    if ($urandom_range(3) == 0) write_register(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(1)),
                                               CFG_DATA_W'($urandom));
  endtask

  // Scans of consecutive rays with random content, mixed with invalid and out-of-window items.
  task automatic test_random_scans();
    logic [RANGE_W-1:0] r;
    logic [RAY_W-1:0]   ray;
    logic               bad;
    int                 kind;
    for (int phase = 0; phase < PHASES; phase++) begin
      randomise_settings();
      calm = (phase == CALM_PHASE);
      ray  = RAY_W'($urandom);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        kind = $urandom_range(99);
        ray  = (kind < 12) ? RAY_W'($urandom) : ray + 1'b1;
        bad  = 1'b0;
        if (kind >= 90) begin
          bad = 1'b1;
          r   = RANGE_W'($urandom);
        end else if (kind >= 82) begin
          r = RANGE_W'($urandom);
        end else if (kind >= 75) begin
          case ($urandom_range(3))
            0: r = m_min;
            1: r = m_max;
            2: r = (m_min == 0) ? m_min : m_min - 1'b1;
            default: r = (m_max == RANGE_TOP) ? m_max : m_max + 1'b1;
          endcase
        end else begin
          r = RANGE_W'($urandom_range(m_max, m_min));
        end
        send_sample(r, ray, bad);
      end
      calm = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    range_value_i    = '0;
    ray_index_i      = '0;
    sample_invalid_i = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    m_start          = '0;
    m_step           = '0;
    m_min            = '0;
    m_max            = RANGE_TOP;
    m_offx           = '0;
    m_offy           = '0;
    gain_q30         = cordic_gain_inverse();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    test_reset_defaults();
    test_quadrant_folding();
    test_range_window();
    test_saturation();
    test_unused_registers();
    test_backpressure();
    test_random_scans();

    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d range items and checked %0d points across %0d register writes.",
             samples_sent, points_checked, writes_done);
    $display("Input was held off for %0d cycles; %0d mismatches were seen.",
             input_stalls, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/p2c_pkg.sv
design/p2c_front.sv
design/p2c_cordic.sv
design/p2c_back.sv
design/scan_polar_to_cartesian_core.sv
test/testbench.sv
